>>> hdl/wcms_pkg.sv
// Package: shared types and constants for the windowed cluster match and sum block.
package wcms_pkg;

    localparam int T_W     = 20;
    localparam int P_W     = 12;
    localparam int D_W     = P_W + 1;
    localparam int E_W     = 16;
    localparam int SQ_W    = 24;
    localparam int DSQ_W   = 25;
    localparam int SUM_W   = 24;
    localparam int IDX_W   = 6;
    localparam int LIM_W   = 16;
    localparam int RAD_W   = 12;
    localparam int R2_W    = 2 * RAD_W;
    localparam int LC_W    = 2;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = Q_PTR_W + 1;

    localparam logic [2:0] REG_WINDOW_LOW  = 3'd0;
    localparam logic [2:0] REG_WINDOW_HIGH = 3'd1;
    localparam logic [2:0] REG_SIM_MODE    = 3'd2;
    localparam logic [2:0] REG_RADIUS      = 3'd3;
    localparam logic [2:0] REG_LOW_LIMIT   = 3'd4;

    localparam logic [T_W-1:0]   WINDOW_LOW_RST  = 20'hFFB00;
    localparam logic [T_W-1:0]   WINDOW_HIGH_RST = 20'd1280;
    localparam logic [RAD_W-1:0] RADIUS_RST      = 12'd600;
    localparam logic [R2_W-1:0]  R2_RST          = 24'd360000;
    localparam logic [LIM_W-1:0] LOW_LIMIT_RST   = 16'd1500;
    localparam logic [DSQ_W-1:0] DIST_ALL_ONES   = {DSQ_W{1'b1}};
    localparam logic [SUM_W-1:0] ENERGY_MAX      = {SUM_W{1'b1}};
    localparam logic [LC_W-1:0]  LOW_SAT         = 2'd2;

    typedef struct packed {
        logic                  has_cluster;
        logic signed [T_W-1:0] ref_time;
        logic signed [T_W-1:0] cluster_time;
        logic [E_W-1:0]        cluster_energy;
        logic signed [P_W-1:0] cluster_x;
        logic signed [P_W-1:0] cluster_y;
        logic signed [P_W-1:0] track_x;
        logic signed [P_W-1:0] track_y;
        logic                  last_cluster;
    } req_t;

    typedef struct packed {
        logic [SUM_W-1:0] energy_total;
        logic             veto_pass;
        logic             matched;
        logic [IDX_W-1:0] matched_index;
        logic [E_W-1:0]   matched_energy;
        logic [DSQ_W-1:0] matched_dist_sq;
    } res_t;

    typedef struct packed {
        logic signed [T_W-1:0] window_low;
        logic signed [T_W-1:0] window_high;
        logic                  sim_mode;
        logic [LIM_W-1:0]      low_energy_limit;
    } cfg_t;

    typedef struct packed {
        logic                  counted;
        logic                  last;
        logic [IDX_W-1:0]      index;
        logic [E_W-1:0]        energy;
        logic                  low;
        logic signed [D_W-1:0] dx;
        logic signed [D_W-1:0] dy;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

>>> hdl/windowed_cluster_match_and_sum_top.sv
// Top level: configuration registers, front end, queue and back end of the cluster match and sum.
// Takes one cluster request per clock while the queue has room and gives one result per
// event, on the request marked last_cluster. A request is classified (time window, cluster
// cap) in the cycle it is accepted and written into a four-entry queue; the back end pops one
// entry per clock while its result is not stalled, through a square, add and accumulate path
// into the result register. Sustained rate is one request per clock without result stalls;
// a stalled result holds the back end while the queue takes requests until it is full. The
// user must write configuration through the APB port while idle; the block does not enforce it.
module windowed_cluster_match_and_sum_top #(
    parameter int MAX_CLUSTERS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wcms_pkg::ADDR_W-1:0]   paddr,
    input  logic [wcms_pkg::DATA_W-1:0]   pwdata,
    output logic [wcms_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  wcms_pkg::req_t                req_data,
    output logic                          res_valid,
    input  logic                          res_stall,
    output wcms_pkg::res_t                res_data
);

    logic [wcms_pkg::T_W-1:0]   window_low_reg;
    logic [wcms_pkg::T_W-1:0]   window_high_reg;
    logic                       sim_mode_reg;
    logic [wcms_pkg::RAD_W-1:0] radius_reg;
    logic [wcms_pkg::LIM_W-1:0] low_limit_reg;
    logic [wcms_pkg::R2_W-1:0]  r2_reg;
    logic [wcms_pkg::R2_W-1:0]  r2_next;
    logic                       wr_en;
    logic [2:0]                 reg_sel;

    wcms_pkg::cfg_t             cfg;
    wcms_pkg::q_entry_t         push_entry;
    wcms_pkg::q_entry_t         head_entry;
    wcms_pkg::q_stat_t          q_stat;
    logic                       q_push;
    logic                       q_pop;

    always_comb
    begin
        pready  = 1'b1;
        wr_en   = psel && penable && pwrite;
        reg_sel = paddr[4:2];
        r2_next = wcms_pkg::R2_W'(radius_reg) * wcms_pkg::R2_W'(radius_reg);
        cfg.window_low       = $signed(window_low_reg);
        cfg.window_high      = $signed(window_high_reg);
        cfg.sim_mode         = sim_mode_reg;
        cfg.low_energy_limit = low_limit_reg;
        req_stall = q_stat.full;
        case (reg_sel)
            wcms_pkg::REG_WINDOW_LOW:  prdata = wcms_pkg::DATA_W'(window_low_reg);
            wcms_pkg::REG_WINDOW_HIGH: prdata = wcms_pkg::DATA_W'(window_high_reg);
            wcms_pkg::REG_SIM_MODE:    prdata = wcms_pkg::DATA_W'(sim_mode_reg);
            wcms_pkg::REG_RADIUS:      prdata = wcms_pkg::DATA_W'(radius_reg);
            wcms_pkg::REG_LOW_LIMIT:   prdata = wcms_pkg::DATA_W'(low_limit_reg);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_low_reg  <= wcms_pkg::WINDOW_LOW_RST;
            window_high_reg <= wcms_pkg::WINDOW_HIGH_RST;
            sim_mode_reg    <= 1'b0;
            radius_reg      <= wcms_pkg::RADIUS_RST;
            low_limit_reg   <= wcms_pkg::LOW_LIMIT_RST;
            r2_reg          <= wcms_pkg::R2_RST;
        end
        else
        begin
            r2_reg <= r2_next;
            if (wr_en)
            begin
                case (reg_sel)
                    wcms_pkg::REG_WINDOW_LOW:  window_low_reg  <= pwdata[wcms_pkg::T_W-1:0];
                    wcms_pkg::REG_WINDOW_HIGH: window_high_reg <= pwdata[wcms_pkg::T_W-1:0];
                    wcms_pkg::REG_SIM_MODE:    sim_mode_reg    <= pwdata[0];
                    wcms_pkg::REG_RADIUS:      radius_reg      <= pwdata[wcms_pkg::RAD_W-1:0];
                    wcms_pkg::REG_LOW_LIMIT:   low_limit_reg   <= pwdata[wcms_pkg::LIM_W-1:0];
                    default:                   ;
                endcase
            end
        end
    end

    wcms_front #(
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req_valid (req_valid),
        .req_data  (req_data),
        .q_full    (q_stat.full),
        .q_push    (q_push),
        .q_entry   (push_entry)
    );

    wcms_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (push_entry),
        .pop      (q_pop),
        .rd_entry (head_entry),
        .stat     (q_stat)
    );

    wcms_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .r2        (r2_reg),
        .q_entry   (head_entry),
        .q_stat    (q_stat),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

`ifndef SYNTHESIS
    a_no_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_data.matched) |-> ((res_data.matched_index == '0)
            && (res_data.matched_energy == '0) && (res_data.matched_dist_sq == '0)))
        else $error("unmatched result carries nonzero match fields");

    a_match_in_radius: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.matched) |-> (res_data.matched_dist_sq < {1'b0, r2_reg}))
        else $error("matched result outside radius");

    a_queue_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty) && !(q_pop && q_stat.empty)
            && !(q_push && q_stat.full))
        else $error("queue overflow or underflow");
`endif

endmodule

>>> hdl/wcms_front.sv
// Front end: accept requests, apply time window and cluster cap, classify into queue entries.
module wcms_front #(
    parameter int MAX_CLUSTERS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  wcms_pkg::cfg_t    cfg,
    input  logic              req_valid,
    input  wcms_pkg::req_t    req_data,
    input  logic              q_full,
    output logic              q_push,
    output wcms_pkg::q_entry_t q_entry
);

    localparam int CNT_W = $clog2(MAX_CLUSTERS + 1);

    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              cnt_next;
    logic signed [wcms_pkg::T_W:0] tdiff;
    logic                          accept;
    logic                          in_window;
    logic                          room;
    logic                          counted;

    always_comb
    begin
        accept = req_valid && !q_full;
        tdiff  = $signed({req_data.ref_time[wcms_pkg::T_W-1], req_data.ref_time})
               - $signed({req_data.cluster_time[wcms_pkg::T_W-1], req_data.cluster_time});
        in_window = cfg.sim_mode
                 || ((tdiff >= $signed({cfg.window_low[wcms_pkg::T_W-1], cfg.window_low}))
                  && (tdiff <= $signed({cfg.window_high[wcms_pkg::T_W-1], cfg.window_high})));
        room    = cnt_reg < CNT_W'(MAX_CLUSTERS);
        counted = req_data.has_cluster && room && in_window;

        cnt_next = cnt_reg;
        if (accept)
        begin
            if (req_data.last_cluster)
            begin
                cnt_next = '0;
            end
            else if (req_data.has_cluster && room)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end

        q_push          = accept && (counted || req_data.last_cluster);
        q_entry.counted = counted;
        q_entry.last    = req_data.last_cluster;
        q_entry.index   = wcms_pkg::IDX_W'(cnt_reg);
        q_entry.energy  = req_data.cluster_energy;
        q_entry.low     = req_data.cluster_energy < cfg.low_energy_limit;
        q_entry.dx      = $signed({req_data.track_x[wcms_pkg::P_W-1], req_data.track_x})
                        - $signed({req_data.cluster_x[wcms_pkg::P_W-1], req_data.cluster_x});
        q_entry.dy      = $signed({req_data.track_y[wcms_pkg::P_W-1], req_data.track_y})
                        - $signed({req_data.cluster_y[wcms_pkg::P_W-1], req_data.cluster_y});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> hdl/wcms_queue.sv
// Queue: short FIFO of classified entries between front and back.
module wcms_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  wcms_pkg::q_entry_t wr_entry,
    input  logic               pop,
    output wcms_pkg::q_entry_t rd_entry,
    output wcms_pkg::q_stat_t  stat
);

    wcms_pkg::q_entry_t          mem_reg [wcms_pkg::Q_DEPTH];
    logic [wcms_pkg::Q_PTR_W-1:0] wr_ptr_reg;
    logic [wcms_pkg::Q_PTR_W-1:0] wr_ptr_next;
    logic [wcms_pkg::Q_PTR_W-1:0] rd_ptr_reg;
    logic [wcms_pkg::Q_PTR_W-1:0] rd_ptr_next;
    logic [wcms_pkg::Q_CNT_W-1:0] count_reg;
    logic [wcms_pkg::Q_CNT_W-1:0] count_next;

    always_comb
    begin
        rd_entry    = mem_reg[rd_ptr_reg];
        stat.full   = count_reg == wcms_pkg::Q_CNT_W'(wcms_pkg::Q_DEPTH);
        stat.empty  = count_reg == '0;
        wr_ptr_next = push ? wr_ptr_reg + wcms_pkg::Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + wcms_pkg::Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + wcms_pkg::Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - wcms_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hdl/wcms_back.sv
// Back end: squared distance pipeline, event accumulation and result register.
module wcms_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [wcms_pkg::R2_W-1:0]   r2,
    input  wcms_pkg::q_entry_t          q_entry,
    input  wcms_pkg::q_stat_t           q_stat,
    output logic                        q_pop,
    output logic                        res_valid,
    input  logic                        res_stall,
    output wcms_pkg::res_t              res_data
);

    logic                           enable;
    logic signed [2*wcms_pkg::D_W-1:0] sqx_full;
    logic signed [2*wcms_pkg::D_W-1:0] sqy_full;

    logic                           s1_valid_reg;
    logic                           s1_counted_reg;
    logic                           s1_last_reg;
    logic [wcms_pkg::IDX_W-1:0]     s1_index_reg;
    logic [wcms_pkg::E_W-1:0]       s1_energy_reg;
    logic                           s1_low_reg;
    logic [wcms_pkg::SQ_W-1:0]      s1_sqx_reg;
    logic [wcms_pkg::SQ_W-1:0]      s1_sqy_reg;

    logic                           s2_valid_reg;
    logic                           s2_counted_reg;
    logic                           s2_last_reg;
    logic [wcms_pkg::IDX_W-1:0]     s2_index_reg;
    logic [wcms_pkg::E_W-1:0]       s2_energy_reg;
    logic                           s2_low_reg;
    logic [wcms_pkg::DSQ_W-1:0]     s2_dsq_reg;

    logic [wcms_pkg::SUM_W-1:0]     acc_reg;
    logic [wcms_pkg::SUM_W-1:0]     acc_next;
    logic [wcms_pkg::LC_W-1:0]      low_cnt_reg;
    logic [wcms_pkg::LC_W-1:0]      low_cnt_next;
    logic [wcms_pkg::DSQ_W-1:0]     best_dsq_reg;
    logic [wcms_pkg::DSQ_W-1:0]     best_dsq_next;
    logic [wcms_pkg::IDX_W-1:0]     best_index_reg;
    logic [wcms_pkg::IDX_W-1:0]     best_index_next;
    logic [wcms_pkg::E_W-1:0]       best_energy_reg;
    logic [wcms_pkg::E_W-1:0]       best_energy_next;

    logic [wcms_pkg::SUM_W:0]       sum;
    logic [wcms_pkg::SUM_W-1:0]     acc_upd;
    logic [wcms_pkg::LC_W-1:0]      low_upd;
    logic [wcms_pkg::DSQ_W-1:0]     best_dsq_upd;
    logic [wcms_pkg::IDX_W-1:0]     best_index_upd;
    logic [wcms_pkg::E_W-1:0]       best_energy_upd;
    logic                           hit;

    logic                           res_valid_reg;
    logic                           res_valid_next;
    wcms_pkg::res_t                 res_data_reg;
    wcms_pkg::res_t                 result;

    always_comb
    begin
        enable   = !res_valid_reg || !res_stall;
        q_pop    = enable && !q_stat.empty;
        sqx_full = $signed(q_entry.dx) * $signed(q_entry.dx);
        sqy_full = $signed(q_entry.dy) * $signed(q_entry.dy);
    end

    // event accumulation on the stage-two entry
    always_comb
    begin
        sum = {1'b0, acc_reg} + (wcms_pkg::SUM_W + 1)'(s2_energy_reg);
        acc_upd = acc_reg;
        low_upd = low_cnt_reg;
        best_dsq_upd    = best_dsq_reg;
        best_index_upd  = best_index_reg;
        best_energy_upd = best_energy_reg;
        if (s2_counted_reg)
        begin
            acc_upd = sum[wcms_pkg::SUM_W] ? wcms_pkg::ENERGY_MAX : sum[wcms_pkg::SUM_W-1:0];
            if (s2_low_reg && (low_cnt_reg != wcms_pkg::LOW_SAT))
            begin
                low_upd = low_cnt_reg + wcms_pkg::LC_W'(1);
            end
            if (s2_dsq_reg < best_dsq_reg)
            begin
                best_dsq_upd    = s2_dsq_reg;
                best_index_upd  = s2_index_reg;
                best_energy_upd = s2_energy_reg;
            end
        end

        hit = best_dsq_upd < {1'b0, r2};
        result.energy_total    = acc_upd;
        result.veto_pass       = low_upd < wcms_pkg::LOW_SAT;
        result.matched         = hit;
        result.matched_index   = hit ? best_index_upd : '0;
        result.matched_energy  = hit ? best_energy_upd : '0;
        result.matched_dist_sq = hit ? best_dsq_upd : '0;

        acc_next         = acc_reg;
        low_cnt_next     = low_cnt_reg;
        best_dsq_next    = best_dsq_reg;
        best_index_next  = best_index_reg;
        best_energy_next = best_energy_reg;
        if (enable && s2_valid_reg)
        begin
            if (s2_last_reg)
            begin
                acc_next         = '0;
                low_cnt_next     = '0;
                best_dsq_next    = wcms_pkg::DIST_ALL_ONES;
                best_index_next  = '0;
                best_energy_next = '0;
            end
            else
            begin
                acc_next         = acc_upd;
                low_cnt_next     = low_upd;
                best_dsq_next    = best_dsq_upd;
                best_index_next  = best_index_upd;
                best_energy_next = best_energy_upd;
            end
        end

        res_valid_next = enable ? (s2_valid_reg && s2_last_reg) : 1'b1;
        res_valid      = res_valid_reg;
        res_data       = res_data_reg;
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            s1_counted_reg <= q_entry.counted;
            s1_last_reg    <= q_entry.last;
            s1_index_reg   <= q_entry.index;
            s1_energy_reg  <= q_entry.energy;
            s1_low_reg     <= q_entry.low;
            s1_sqx_reg     <= sqx_full[wcms_pkg::SQ_W-1:0];
            s1_sqy_reg     <= sqy_full[wcms_pkg::SQ_W-1:0];
            s2_counted_reg <= s1_counted_reg;
            s2_last_reg    <= s1_last_reg;
            s2_index_reg   <= s1_index_reg;
            s2_energy_reg  <= s1_energy_reg;
            s2_low_reg     <= s1_low_reg;
            s2_dsq_reg     <= {1'b0, s1_sqx_reg} + {1'b0, s1_sqy_reg};
            if (s2_valid_reg && s2_last_reg)
            begin
                res_data_reg <= result;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            res_valid_reg   <= 1'b0;
            acc_reg         <= '0;
            low_cnt_reg     <= '0;
            best_dsq_reg    <= wcms_pkg::DIST_ALL_ONES;
            best_index_reg  <= '0;
            best_energy_reg <= '0;
        end
        else
        begin
            if (enable)
            begin
                s1_valid_reg <= !q_stat.empty;
                s2_valid_reg <= s1_valid_reg;
            end
            res_valid_reg   <= res_valid_next;
            acc_reg         <= acc_next;
            low_cnt_reg     <= low_cnt_next;
            best_dsq_reg    <= best_dsq_next;
            best_index_reg  <= best_index_next;
            best_energy_reg <= best_energy_next;
        end
    end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench for the cluster match-and-sum top: directed and random requests, scoreboard check.
module tb;

    localparam int MAX_CLUSTERS = 64;
    localparam int T_MIN = -524288;
    localparam int T_MAX = 524287;
    localparam int P_MIN = -2048;
    localparam int P_MAX = 2047;
    localparam int TD_LIM = 1048575;
    localparam int PHASE_ITEMS = 300;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 16;

    typedef struct {
        wcms_pkg::req_t req;
        bit             typed;
        wcms_pkg::res_t want;
    } stim_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [wcms_pkg::ADDR_W-1:0] paddr;
    logic [wcms_pkg::DATA_W-1:0] pwdata;
    logic [wcms_pkg::DATA_W-1:0] prdata;
    logic                        pready;
    logic                        req_valid;
    logic                        req_stall;
    wcms_pkg::req_t              req_data;
    logic                        res_valid;
    logic                        res_stall;
    wcms_pkg::res_t              res_data;

    logic signed [wcms_pkg::T_W-1:0] cfg_wlow;
    logic signed [wcms_pkg::T_W-1:0] cfg_whigh;
    logic                            cfg_sim;
    logic [wcms_pkg::RAD_W-1:0]      cfg_radius;
    logic [wcms_pkg::LIM_W-1:0]      cfg_limit;

    logic [wcms_pkg::SUM_W-1:0] ev_energy;
    logic [wcms_pkg::LC_W-1:0]  ev_low;
    logic [wcms_pkg::DSQ_W-1:0] ev_best_dsq;
    logic [wcms_pkg::IDX_W-1:0] ev_best_idx;
    logic [wcms_pkg::E_W-1:0]   ev_best_e;
    int                         ev_count;

    wcms_pkg::res_t event_results_q[$];
    stim_row_t      stim_rows[$];

    int errors = 0;
    int useful = 0;
    int results_seen = 0;
    int settings = 1;
    int long_events = 0;
    int tx_mode = 1;
    int rx_mode = 1;
    bit hold_rx = 1'b0;

    windowed_cluster_match_and_sum_top #(
        .MAX_CLUSTERS(MAX_CLUSTERS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("windowed_cluster_match_and_sum_top verification failed");
        $finish;
    end

    function automatic int rand_in(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int draw_gap(int mode);
        if (mode == 0)
            return 0;
        if (mode == 1)
            return rand_in(0, 16);
        return ($urandom_range(7) == 0) ? rand_in(0, 16) : 0;
    endfunction

    function automatic wcms_pkg::req_t mk_req(bit has, int rt, int ct, int e, int cx, int cy,
                                              int tx, int ty, bit last);
        wcms_pkg::req_t r;
        r.has_cluster    = has;
        r.ref_time       = wcms_pkg::T_W'(rt);
        r.cluster_time   = wcms_pkg::T_W'(ct);
        r.cluster_energy = wcms_pkg::E_W'(e);
        r.cluster_x      = wcms_pkg::P_W'(cx);
        r.cluster_y      = wcms_pkg::P_W'(cy);
        r.track_x        = wcms_pkg::P_W'(tx);
        r.track_y        = wcms_pkg::P_W'(ty);
        r.last_cluster   = last;
        return r;
    endfunction

    function automatic wcms_pkg::res_t mk_res(int e, bit veto, bit m, int idx, int me, int dsq);
        wcms_pkg::res_t r;
        r.energy_total    = wcms_pkg::SUM_W'(e);
        r.veto_pass       = veto;
        r.matched         = m;
        r.matched_index   = wcms_pkg::IDX_W'(idx);
        r.matched_energy  = wcms_pkg::E_W'(me);
        r.matched_dist_sq = wcms_pkg::DSQ_W'(dsq);
        return r;
    endfunction

    function automatic wcms_pkg::req_t noise_req(bit last);
        return mk_req(1'b0, rand_in(T_MIN, T_MAX), rand_in(T_MIN, T_MAX), rand_in(0, 65535),
                      rand_in(P_MIN, P_MAX), rand_in(P_MIN, P_MAX), rand_in(P_MIN, P_MAX),
                      rand_in(P_MIN, P_MAX), last);
    endfunction

    function automatic wcms_pkg::req_t gen_cluster(int ev_ref, int tx, int ty, bit last);
        int wl;
        int wh;
        int td;
        int rt;
        int ct;
        int lo;
        int hi;
        int lim;
        int ox;
        int oy;
        int cx;
        int cy;
        int e;
        int sel;
        wl = int'(cfg_wlow);
        wh = int'(cfg_whigh);
        sel = $urandom_range(9);
        case (sel)
            0: td = wl - 1;
            1: td = wl;
            2: td = wh;
            3: td = wh + 1;
            4: td = rand_in(-TD_LIM, TD_LIM);
            default: td = (wl <= wh) ? rand_in(wl, wh) : rand_in(wh, wl);
        endcase
        td = clamp(td, -TD_LIM, TD_LIM);
        rt = ($urandom_range(4) == 0) ? rand_in(T_MIN, T_MAX) : ev_ref;
        ct = rt - td;
        if (ct < T_MIN || ct > T_MAX)
        begin
            lo = (T_MIN - td > T_MIN) ? T_MIN - td : T_MIN;
            hi = (T_MAX - td < T_MAX) ? T_MAX - td : T_MAX;
            ct = rand_in(lo, hi);
            rt = ct + td;
        end
        lim = int'(cfg_radius) + 2;
        sel = $urandom_range(7);
        if (sel < 2)
        begin
            cx = rand_in(P_MIN, P_MAX);
            cy = rand_in(P_MIN, P_MAX);
        end
        else
        begin
            if (sel == 2)
            begin
                ox = int'(cfg_radius);
                oy = 0;
            end
            else if (sel == 3)
            begin
                ox = rand_in(-3, 3);
                oy = rand_in(-3, 3);
            end
            else
            begin
                ox = rand_in(-lim, lim);
                oy = rand_in(-lim, lim);
            end
            cx = clamp(tx + ox, P_MIN, P_MAX);
            cy = clamp(ty + oy, P_MIN, P_MAX);
        end
        sel = $urandom_range(7);
        case (sel)
            0: e = 0;
            1: e = 65535;
            2: e = clamp(int'(cfg_limit) - 1, 0, 65535);
            3: e = int'(cfg_limit);
            default: e = rand_in(0, 65535);
        endcase
        return mk_req(1'b1, rt, ct, e, cx, cy, tx, ty, last);
    endfunction

    task automatic clear_event();
        ev_energy   = '0;
        ev_low      = '0;
        ev_best_dsq = wcms_pkg::DIST_ALL_ONES;
        ev_best_idx = '0;
        ev_best_e   = '0;
        ev_count    = 0;
    endtask

    task automatic reset_model();
        cfg_wlow   = wcms_pkg::T_W'(-1280);
        cfg_whigh  = wcms_pkg::T_W'(1280);
        cfg_sim    = 1'b0;
        cfg_radius = wcms_pkg::RAD_W'(600);
        cfg_limit  = wcms_pkg::LIM_W'(1500);
        clear_event();
    endtask

    task automatic predict_event(input wcms_pkg::req_t r, output bit got,
                                 output wcms_pkg::res_t res);
        int td;
        int dx;
        int dy;
        int dsq;
        int sum;
        int r2;
        bit counted;
        got = 1'b0;
        res = wcms_pkg::res_t'(0);
        if (r.has_cluster && ev_count < MAX_CLUSTERS)
        begin
            td = int'($signed(r.ref_time)) - int'($signed(r.cluster_time));
            counted = cfg_sim || (td >= int'(cfg_wlow) && td <= int'(cfg_whigh));
            if (counted)
            begin
                dx = int'($signed(r.track_x)) - int'($signed(r.cluster_x));
                dy = int'($signed(r.track_y)) - int'($signed(r.cluster_y));
                dsq = dx * dx + dy * dy;
                sum = int'(ev_energy) + int'(r.cluster_energy);
                ev_energy = (sum > int'(wcms_pkg::ENERGY_MAX)) ? wcms_pkg::ENERGY_MAX
                                                               : wcms_pkg::SUM_W'(sum);
                if (r.cluster_energy < cfg_limit && ev_low < wcms_pkg::LOW_SAT)
                    ev_low = ev_low + 1'b1;
                if (dsq < int'(ev_best_dsq))
                begin
                    ev_best_dsq = wcms_pkg::DSQ_W'(dsq);
                    ev_best_idx = wcms_pkg::IDX_W'(ev_count);
                    ev_best_e   = r.cluster_energy;
                end
            end
            ev_count++;
        end
        if (r.last_cluster)
        begin
            r2 = int'(cfg_radius) * int'(cfg_radius);
            got = 1'b1;
            res.energy_total = ev_energy;
            res.veto_pass = (ev_low <= 1);
            if (int'(ev_best_dsq) < r2)
            begin
                res.matched         = 1'b1;
                res.matched_index   = ev_best_idx;
                res.matched_energy  = ev_best_e;
                res.matched_dist_sq = ev_best_dsq;
            end
            clear_event();
        end
    endtask

    task automatic send_req(input wcms_pkg::req_t r, input bit typed,
                            input wcms_pkg::res_t want);
        bit             got;
        wcms_pkg::res_t res;
        int             gap;
        gap = draw_gap(tx_mode);
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (r.last_cluster || (r.has_cluster && ev_count < MAX_CLUSTERS))
            useful++;
        predict_event(r, got, res);
        if (got)
            event_results_q.push_back(typed ? want : res);
    endtask

    task automatic settle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (event_results_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] reg_idx,
                             input logic [wcms_pkg::DATA_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(int wl, int wh, bit sim, int rad, int lim);
        apb_write(wcms_pkg::REG_WINDOW_LOW, wcms_pkg::DATA_W'(wl));
        apb_write(wcms_pkg::REG_WINDOW_HIGH, wcms_pkg::DATA_W'(wh));
        apb_write(wcms_pkg::REG_SIM_MODE, wcms_pkg::DATA_W'(sim));
        apb_write(wcms_pkg::REG_RADIUS, wcms_pkg::DATA_W'(rad));
        apb_write(wcms_pkg::REG_LOW_LIMIT, wcms_pkg::DATA_W'(lim));
        cfg_wlow   = wcms_pkg::T_W'(wl);
        cfg_whigh  = wcms_pkg::T_W'(wh);
        cfg_sim    = sim;
        cfg_radius = wcms_pkg::RAD_W'(rad);
        cfg_limit  = wcms_pkg::LIM_W'(lim);
        settings++;
    endtask

    task automatic run_event();
        int n;
        int ev_ref;
        int tx;
        int ty;
        bit close_empty;
        n = ($urandom_range(49) == 0) ? MAX_CLUSTERS + rand_in(1, 6) : rand_in(0, 7);
        if (n > MAX_CLUSTERS)
            long_events++;
        ev_ref = rand_in(T_MIN, T_MAX);
        tx = rand_in(P_MIN, P_MAX);
        ty = rand_in(P_MIN, P_MAX);
        close_empty = (n == 0) || ($urandom_range(9) == 0);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(11) == 0)
                send_req(noise_req(1'b0), 1'b0, wcms_pkg::res_t'(0));
            send_req(gen_cluster(ev_ref, tx, ty, !close_empty && k == n - 1), 1'b0,
                     wcms_pkg::res_t'(0));
        end
        if (close_empty)
            send_req(noise_req(1'b1), 1'b0, wcms_pkg::res_t'(0));
    endtask

    task automatic build_directed();
        stim_rows.push_back('{mk_req(1'b0, 0, 0, 0, 0, 0, 0, 0, 1'b1), 1'b1,
                              mk_res(0, 1'b1, 1'b0, 0, 0, 0)});
        stim_rows.push_back('{mk_req(1'b1, 0, 0, 65535, 0, 0, 0, 0, 1'b1), 1'b1,
                              mk_res(65535, 1'b1, 1'b1, 0, 65535, 0)});
        stim_rows.push_back('{mk_req(1'b1, 1281, 0, 100, 5, 5, 5, 5, 1'b1), 1'b1,
                              mk_res(0, 1'b1, 1'b0, 0, 0, 0)});
        stim_rows.push_back('{mk_req(1'b1, 0, 1281, 100, 5, 5, 5, 5, 1'b1), 1'b1,
                              mk_res(0, 1'b1, 1'b0, 0, 0, 0)});
        stim_rows.push_back('{mk_req(1'b1, 1280, 0, 100, 103, -196, 100, -200, 1'b0), 1'b0,
                              wcms_pkg::res_t'(0)});
        stim_rows.push_back('{mk_req(1'b1, 0, 1280, 200, 100, -200, 100, -200, 1'b1), 1'b0,
                              wcms_pkg::res_t'(0)});
        stim_rows.push_back('{mk_req(1'b1, T_MAX, T_MAX, 0, P_MIN, P_MIN, P_MAX, P_MAX, 1'b0),
                              1'b0, wcms_pkg::res_t'(0)});
        stim_rows.push_back('{mk_req(1'b0, -1, -1, 65535, -1, -1, -1, -1, 1'b0), 1'b0,
                              wcms_pkg::res_t'(0)});
        stim_rows.push_back('{mk_req(1'b1, T_MAX, T_MIN, 65535, 0, 0, 0, 0, 1'b0), 1'b0,
                              wcms_pkg::res_t'(0)});
        stim_rows.push_back('{mk_req(1'b1, T_MIN, T_MAX, 65535, 0, 0, 0, 0, 1'b0), 1'b0,
                              wcms_pkg::res_t'(0)});
        stim_rows.push_back('{mk_req(1'b1, -300, -300, 1499, -401, 700, -1000, 700, 1'b0),
                              1'b0, wcms_pkg::res_t'(0)});
        stim_rows.push_back('{mk_req(1'b1, -300, -300, 1500, -1000, 1299, -1000, 700, 1'b0),
                              1'b0, wcms_pkg::res_t'(0)});
        stim_rows.push_back('{mk_req(1'b1, -300, -300, 2000, -400, 700, -1000, 700, 1'b1),
                              1'b0, wcms_pkg::res_t'(0)});
        stim_rows.push_back('{mk_req(1'b1, 10, 11, 65535, P_MAX, P_MIN, P_MAX, P_MIN, 1'b0),
                              1'b0, wcms_pkg::res_t'(0)});
        stim_rows.push_back('{mk_req(1'b0, T_MIN, T_MAX, 0, P_MAX, P_MAX, P_MIN, P_MIN, 1'b1),
                              1'b0, wcms_pkg::res_t'(0)});
        stim_rows.push_back('{mk_req(1'b1, 0, 0, 1500, 600, 0, 0, 0, 1'b1), 1'b1,
                              mk_res(1500, 1'b1, 1'b0, 0, 0, 0)});
        stim_rows.push_back('{mk_req(1'b1, 0, 0, 1, P_MAX, P_MIN, P_MIN, P_MAX, 1'b1), 1'b0,
                              wcms_pkg::res_t'(0)});
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        wcms_pkg::res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (event_results_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got energy_total %0d",
                         $time, res_data.energy_total);
                errors++;
            end
            else
            begin
                want = event_results_q.pop_front();
                results_seen++;
                check_field("energy_total", want.energy_total, res_data.energy_total);
                check_field("veto_pass", want.veto_pass, res_data.veto_pass);
                check_field("matched", want.matched, res_data.matched);
                check_field("matched_index", want.matched_index, res_data.matched_index);
                check_field("matched_energy", want.matched_energy, res_data.matched_energy);
                check_field("matched_dist_sq", want.matched_dist_sq, res_data.matched_dist_sq);
            end
        end
    end

    initial
    begin
        int stall_n;
        res_stall = 1'b0;
        forever
        begin
            stall_n = draw_gap(rx_mode);
            if (hold_rx)
            begin
                stall_n = HOLD_CYCLES;
                hold_rx = 1'b0;
            end
            @(negedge clk);
            if (stall_n > 0)
            begin
                res_stall <= 1'b1;
                repeat (stall_n) @(negedge clk);
            end
            res_stall <= 1'b0;
            @(posedge clk);
            while (!(rst_n && res_valid))
                @(posedge clk);
        end
    end

    initial
    begin
        int target;
        bit paused;
        bit held;
        paused    = 1'b0;
        held      = 1'b0;
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        req_valid = 1'b0;
        req_data  = '0;
        reset_model();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        build_directed();
        foreach (stim_rows[i])
            send_req(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].want);

        for (int p = 0; p < 6; p++)
        begin
            settle();
            case (p)
                0: set_config(-2000, 3000, 1'b0, 1000, 2000);
                1: set_config(T_MIN, T_MAX, 1'b0, 4095, 65535);
                2: set_config(100, -100, 1'b0, 0, 0);
                3: set_config(T_MAX, T_MIN, 1'b1, 4095, 0);
                4: set_config(0, 0, 1'b0, 1, 65535);
                default: set_config(-800, 800, 1'b1, 300, 1500);
            endcase
            tx_mode = p % 3;
            rx_mode = (p + 1) % 3;
            target = useful + PHASE_ITEMS;
            while (useful < target)
            begin
                if (p == 0 && !paused && useful >= target - PHASE_ITEMS / 2)
                begin
                    settle();
                    paused = 1'b1;
                end
                if (p == 1 && !held && useful >= target - PHASE_ITEMS + 40)
                begin
                    tx_mode = 0;
                    hold_rx = 1'b1;
                    held = 1'b1;
                end
                run_event();
            end
        end
        settle();

        $display("Checked %0d event results from %0d requests across %0d register settings,",
                 results_seen, useful, settings);
        $display("with %0d over-length events, a long result hold-off and a drain pause.",
                 long_events);
        if (errors == 0 && event_results_q.size() == 0)
            $display("windowed_cluster_match_and_sum_top verification clean");
        else
            $display("windowed_cluster_match_and_sum_top verification failed");
        $finish;
    end

endmodule

>>> files.f
hdl/wcms_pkg.sv
hdl/wcms_front.sv
hdl/wcms_queue.sv
hdl/wcms_back.sv
hdl/windowed_cluster_match_and_sum_top.sv
tb/sv/tb.sv
